>>> src/cascaded_three_axis_pid_unit_defines.svh
// ----------------------------------------------------------------------------
// Cascaded three-axis PID unit: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CASCADED_THREE_AXIS_PID_UNIT_DEFINES_SVH
`define CASCADED_THREE_AXIS_PID_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define CTPID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define CTPID_ASSERT_NEVER(lbl, cond, msg) \
  `CTPID_ASSERT(lbl, !(cond), msg)

`endif

>>> src/ctpid_pkg.sv
// ----------------------------------------------------------------------------
// ctpid_pkg
// Shared widths, register codes, types and saturation helper of the
// cascaded PID unit.
// ----------------------------------------------------------------------------
package ctpid_pkg;

  localparam int DATA_W     = 32;
  localparam int GAIN_W     = 23;
  localparam int PER_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int NUM_AX     = 3;
  localparam int NUM_ST     = 3;

  localparam int DIFF_W     = DATA_W + 1;
  localparam int MUL_A_W    = DATA_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 2;

  // divider: quotient bits retired per cycle
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = DATA_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_ACCEL_PERIOD = 3'd3,
    REG_VEL_PERIOD   = 3'd4,
    REG_ANGLE_PERIOD = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0]             prop;
    logic [GAIN_W-1:0]             integ;
    logic [GAIN_W-1:0]             deriv;
    logic [NUM_ST-1:0][PER_W-1:0]  period;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [63:0] v);
    if (v > S32_MAX_W) begin
      return S32_MAX_W[DATA_W-1:0];
    end else if (v < S32_MIN_W) begin
      return S32_MIN_W[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> src/ctpid_if.sv
// ----------------------------------------------------------------------------
// ctpid channel interfaces
// Sample input, thrust result and configuration write channels.
// ----------------------------------------------------------------------------
interface ctpid_sample_if import ctpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] accel_x;
  logic signed [DATA_W-1:0] accel_y;
  logic signed [DATA_W-1:0] accel_z;
  logic signed [DATA_W-1:0] target_accel_x;
  logic signed [DATA_W-1:0] target_accel_y;
  logic signed [DATA_W-1:0] target_accel_z;
  logic signed [DATA_W-1:0] velocity_x;
  logic signed [DATA_W-1:0] velocity_y;
  logic signed [DATA_W-1:0] velocity_z;
  logic signed [DATA_W-1:0] angle_x;
  logic signed [DATA_W-1:0] angle_y;
  logic signed [DATA_W-1:0] angle_z;

  modport source (
    output valid, accel_x, accel_y, accel_z,
    output target_accel_x, target_accel_y, target_accel_z,
    output velocity_x, velocity_y, velocity_z, angle_x, angle_y, angle_z,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z,
    input  target_accel_x, target_accel_y, target_accel_z,
    input  velocity_x, velocity_y, velocity_z, angle_x, angle_y, angle_z,
    output ready
  );
endinterface

interface ctpid_result_if import ctpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] thrust_x;
  logic signed [DATA_W-1:0] thrust_y;
  logic signed [DATA_W-1:0] thrust_z;

  modport source (output valid, thrust_x, thrust_y, thrust_z, input ready);
  modport sink (input valid, thrust_x, thrust_y, thrust_z, output ready);
endinterface

interface ctpid_cfg_if import ctpid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink (input valid, reg_idx, wdata, output ready);
endinterface

>>> src/ctpid_cfg.sv
// ----------------------------------------------------------------------------
// ctpid_cfg
// Gain and period register file, written over the configuration channel.
// ----------------------------------------------------------------------------
module ctpid_cfg import ctpid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctpid_cfg_if.sink   cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop   <= GAIN_W'(65536);
      cfg_q.integ  <= GAIN_W'(6554);
      cfg_q.deriv  <= GAIN_W'(655);
      cfg_q.period <= {NUM_ST{PER_W'(66)}};
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_idx)
        REG_PROP_GAIN:    cfg_q.prop      <= cfg_i.wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:   cfg_q.integ     <= cfg_i.wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:   cfg_q.deriv     <= cfg_i.wdata[GAIN_W-1:0];
        REG_ACCEL_PERIOD: cfg_q.period[0] <= cfg_i.wdata[PER_W-1:0];
        REG_VEL_PERIOD:   cfg_q.period[1] <= cfg_i.wdata[PER_W-1:0];
        REG_ANGLE_PERIOD: cfg_q.period[2] <= cfg_i.wdata[PER_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

>>> src/ctpid_mul.sv
// ----------------------------------------------------------------------------
// ctpid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ctpid_mul import ctpid_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> src/ctpid_div.sv
// ----------------------------------------------------------------------------
// ctpid_div
// Iterative divider for the derivative term: (diff << FRAC_BITS) / period,
// truncated toward zero and saturated to 32 bits. Retires DIV_BITS quotient
// bits per cycle.
// ----------------------------------------------------------------------------
module ctpid_div import ctpid_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [DIFF_W-1:0] dividend_i,
  input  logic [PER_W-1:0]         divisor_i,
  output div_stat_t                stat_o,
  output logic signed [DATA_W-1:0] quot_o
);

  localparam int NW = DATA_W + FRAC_BITS;

  logic                     busy_q, done_q;
  logic [DIV_CNT_W-1:0]     cnt_q;
  logic                     neg_q, ovf_q;
  logic [PER_W-1:0]         rem_q, den_q;
  logic [DATA_W-1:0]        shf_q, quo_q;
  logic signed [DATA_W-1:0] quot_q;

  logic [DATA_W-1:0] mag;
  logic [NW-1:0]     num, num_hi;
  logic              ovf_start;

  logic [PER_W-1:0]  rem_d;
  logic [DATA_W-1:0] shf_d, quo_d;
  logic signed [DATA_W-1:0] res_d;

  // |diff| fits 32 bits; numerator is |diff| scaled by the fraction bits.
  always_comb begin
    mag       = dividend_i[DIFF_W-1] ? DATA_W'(-dividend_i) : DATA_W'(dividend_i);
    num       = {mag, {FRAC_BITS{1'b0}}};
    num_hi    = NW'(num >> DATA_W);
    // quotient needs more than 32 bits -> saturate directly
    ovf_start = num_hi >= NW'(divisor_i);
  end

  always_comb begin
    logic [PER_W:0] t;
    rem_d = rem_q;
    shf_d = shf_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      t     = {rem_d, shf_d[DATA_W-1]};
      shf_d = shf_d << 1;
      if (t >= {1'b0, den_q}) begin
        rem_d = PER_W'(t - {1'b0, den_q});
        quo_d = {quo_d[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = t[PER_W-1:0];
        quo_d = {quo_d[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (ovf_q) begin
      res_d = neg_q ? S32_MIN_W[DATA_W-1:0] : S32_MAX_W[DATA_W-1:0];
    end else if (!neg_q) begin
      res_d = quo_d[DATA_W-1] ? S32_MAX_W[DATA_W-1:0] : $signed(quo_d);
    end else if (quo_d[DATA_W-1] && (|quo_d[DATA_W-2:0])) begin
      res_d = S32_MIN_W[DATA_W-1:0];
    end else begin
      res_d = $signed(~quo_d + DATA_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIFF_W-1];
      ovf_q <= ovf_start;
      rem_q <= PER_W'(num_hi);
      den_q <= divisor_i;
      shf_q <= num[DATA_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
      quo_q <= quo_d;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        quot_q <= res_d;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

>>> src/cascaded_three_axis_pid_unit.sv
// ----------------------------------------------------------------------------
// cascaded_three_axis_pid_unit
// Three cascaded PID stages (acceleration, velocity, angle) over three axes,
// run one controller at a time on a shared multiplier and divider.
// ----------------------------------------------------------------------------
//
//  channel   | port      | dir | payload
//  ----------+-----------+-----+----------------------------------------------
//  sample    | sample_i  | in  | accel, target_accel, velocity, angle (x/y/z)
//  result    | thrust_o  | out | thrust_x, thrust_y, thrust_z
//  config    | cfg_i     | in  | reg_idx (0..5), wdata
//
//  Each controller steps through the error, e*dt product, integral update,
//  the divider wait (4 quotient bits per cycle), then three gain
//  products and the final sum and write-back. A sample runs all
//  AXES*STAGES controllers in turn before its result is handed over; the
//  next sample can transfer only once the sequencer is back in idle.
//  sample_i.ready is high only while the sequencer is idle; a pending result
//  does not block the next sample transfer, only the hand-off of the next one.
//  Reset clears the gains/periods to defaults and all integrals/errors to 0.
//
`include "cascaded_three_axis_pid_unit_defines.svh"

module cascaded_three_axis_pid_unit import ctpid_pkg::*; #(
  parameter int AXES      = 3,
  parameter int STAGES    = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ctpid_cfg_if.sink        cfg_i,
  ctpid_sample_if.sink     sample_i,
  ctpid_result_if.source   thrust_o
);

  localparam int NCTL  = AXES * STAGES;
  localparam int IDX_W = (NCTL > 1)   ? $clog2(NCTL)   : 1;
  localparam int ST_W  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int AX_W  = (AXES > 1)   ? $clog2(AXES)   : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,   // e = sat(target - measured)
    ST_EDT,   // multiplier: e * dt, latch e - e_prev
    ST_INT,   // integral update, kick divider
    ST_DIV,   // wait for derivative quotient
    ST_KP,    // multiplier: kp * e
    ST_KI,    // acc = kp*e, multiplier: ki * I
    ST_KD,    // acc += ki*I, multiplier: kd * D
    ST_SUM,   // acc += kd*D
    ST_OUT,   // scale, saturate, write controller state back
    ST_DONE   // hand result to output register
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  cfg_t cfg;

  ctpid_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e                   state_q;
  logic [ST_W-1:0]          stage_q;
  logic [AX_W-1:0]          axis_q;
  logic                     out_valid_q;

  // per-controller state, index stage*AXES + axis
  logic signed [DATA_W-1:0] integ_mem_q [NCTL];
  logic signed [DATA_W-1:0] prev_mem_q  [NCTL];

  logic signed [DATA_W-1:0] meas_q  [STAGES][AXES];
  logic signed [DATA_W-1:0] carry_q [NUM_AX];   // target of the current stage
  logic signed [DATA_W-1:0] e_q, integ_q, der_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] thrust_q [NUM_AX];

  // --------------------------------------------------------------------------
  // Input fields grouped by stage
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] in_meas [NUM_ST][NUM_AX];
  logic signed [DATA_W-1:0] in_tgt  [NUM_AX];

  always_comb begin
    in_meas[0][0] = sample_i.accel_x;
    in_meas[0][1] = sample_i.accel_y;
    in_meas[0][2] = sample_i.accel_z;
    in_meas[1][0] = sample_i.velocity_x;
    in_meas[1][1] = sample_i.velocity_y;
    in_meas[1][2] = sample_i.velocity_z;
    in_meas[2][0] = sample_i.angle_x;
    in_meas[2][1] = sample_i.angle_y;
    in_meas[2][2] = sample_i.angle_z;
    in_tgt[0]     = sample_i.target_accel_x;
    in_tgt[1]     = sample_i.target_accel_y;
    in_tgt[2]     = sample_i.target_accel_z;
  end

  // --------------------------------------------------------------------------
  // Datapath around the shared units
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]          idx;
  logic [PER_W-1:0]          per_stage [STAGES];
  logic [PER_W-1:0]          per_sel, dt_eff;
  logic signed [DATA_W-1:0]  e_next, integ_next, out_next;
  logic signed [PROD_W-1:0]  mul_prod, prod_sh;
  logic signed [ACC_W-1:0]   acc_sh;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                      div_start;
  logic signed [DATA_W-1:0]  div_quot;
  div_stat_t                 div_stat;
  logic                      in_xfer, out_free;

  for (genvar s = 0; s < STAGES; s++) begin : g_per
    assign per_stage[s] = cfg.period[s];
  end

  assign idx     = IDX_W'(int'(stage_q) * AXES + int'(axis_q));
  assign per_sel = per_stage[stage_q];
  assign dt_eff  = (per_sel == '0) ? PER_W'(1) : per_sel;   // zero period acts as 1

  assign e_next     = sat_s32(64'(carry_q[axis_q]) - 64'(meas_q[stage_q][axis_q]));
  assign prod_sh    = mul_prod >>> FRAC_BITS;                // floor of e*dt / 2^F
  assign integ_next = sat_s32(64'(integ_mem_q[idx]) + 64'(prod_sh));
  assign acc_sh     = acc_q >>> FRAC_BITS;
  assign out_next   = sat_s32(64'(acc_sh));

  // gains and periods are unsigned: zero-extend into the signed operand
  always_comb begin
    mul_a = MUL_A_W'(e_q);
    mul_b = '0;
    case (state_q)
      ST_EDT: mul_b = $signed(MUL_B_W'(dt_eff));
      ST_KP:  mul_b = $signed(MUL_B_W'(cfg.prop));
      ST_KI: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = $signed(MUL_B_W'(cfg.integ));
      end
      ST_KD: begin
        mul_a = MUL_A_W'(der_q);
        mul_b = $signed(MUL_B_W'(cfg.deriv));
      end
      default: ;
    endcase
  end

  ctpid_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  assign div_start = (state_q == ST_INT);

  ctpid_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (diff_q),
    .divisor_i  (dt_eff),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid && (state_q == ST_IDLE);
  assign out_free       = !out_valid_q || thrust_o.ready;

  assign thrust_o.valid    = out_valid_q;
  assign thrust_o.thrust_x = thrust_q[0];
  assign thrust_o.thrust_y = thrust_q[1];
  assign thrust_o.thrust_z = thrust_q[2];

  // --------------------------------------------------------------------------
  // Sequencer, controller state and output valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NCTL; i++) begin
        integ_mem_q[i] <= '0;
        prev_mem_q[i]  <= '0;
      end
    end else begin
      // new result loads as the old one leaves, else valid drops on transfer
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (thrust_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            stage_q <= '0;
            axis_q  <= '0;
            state_q <= ST_ERR;
          end
        end
        ST_ERR: state_q <= ST_EDT;
        ST_EDT: state_q <= ST_INT;
        ST_INT: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= ST_KP;
          end
        end
        ST_KP:  state_q <= ST_KI;
        ST_KI:  state_q <= ST_KD;
        ST_KD:  state_q <= ST_SUM;
        ST_SUM: state_q <= ST_OUT;
        ST_OUT: begin
          integ_mem_q[idx] <= integ_q;
          prev_mem_q[idx]  <= e_q;
          if (axis_q == AX_W'(AXES - 1)) begin
            axis_q <= '0;
            if (stage_q == ST_W'(STAGES - 1)) begin
              state_q <= ST_DONE;
            end else begin
              stage_q <= stage_q + ST_W'(1);
              state_q <= ST_ERR;
            end
          end else begin
            axis_q  <= axis_q + AX_W'(1);
            state_q <= ST_ERR;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int s = 0; s < STAGES; s++) begin
        for (int a = 0; a < AXES; a++) begin
          meas_q[s][a] <= in_meas[s][a];
        end
      end
      for (int a = 0; a < NUM_AX; a++) begin
        carry_q[a] <= in_tgt[a];
      end
    end
    case (state_q)
      ST_ERR:  e_q     <= e_next;
      ST_EDT:  diff_q  <= DIFF_W'(e_q) - DIFF_W'(prev_mem_q[idx]);
      ST_INT:  integ_q <= integ_next;
      ST_DIV:  der_q   <= div_quot;
      ST_KI:   acc_q   <= ACC_W'(mul_prod);
      ST_KD:   acc_q   <= acc_q + ACC_W'(mul_prod);
      ST_SUM:  acc_q   <= acc_q + ACC_W'(mul_prod);
      ST_OUT:  carry_q[axis_q] <= out_next;   // next stage's target
      ST_DONE: begin
        if (out_free) begin
          // axes not computed read 0
          for (int a = 0; a < NUM_AX; a++) begin
            thrust_q[a] <= (a < AXES) ? carry_q[a] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CTPID_ASSERT(a_xfer_starts_seq, in_xfer |=> (state_q == ST_ERR), "sample transfer did not start the sequencer")
  `CTPID_ASSERT(a_div_only_in_div, div_stat.busy |-> (state_q == ST_DIV), "divider busy outside its wait state")
  `CTPID_ASSERT(a_ctr_in_range, (stage_q <= ST_W'(STAGES - 1)) && (axis_q <= AX_W'(AXES - 1)), "stage or axis counter out of range")
  `CTPID_ASSERT(a_result_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE), "result presented without finishing a sample")

endmodule

>>> verif/cascaded_three_axis_pid_unit_tb.sv
// ----------------------------------------------------------------------------
// cascaded_three_axis_pid_unit_tb
// Self-checking bench for the cascaded three-axis PID unit. Samples are driven
// over the sample channel and each thrust transfer is compared with a bit-true
// cascade predictor that keeps its own integrals, last errors and registers.
// Covers reset defaults, field extremes, register extremes, random register
// settings, tracking and noisy sample streams, drain pauses and full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascaded_three_axis_pid_unit_tb;
  import ctpid_pkg::*;

  localparam int  CLK_PERIOD     = 10;
  localparam int  FRAC_BITS      = 16;
  localparam int  NUM_FIELDS     = 12;
  localparam int  NUM_CTRL       = NUM_ST * NUM_AX;
  // span from a sample transfer to its result, sizes the final settling wait
  localparam int  SAMPLE_LATENCY = 17 * NUM_CTRL + 1;
  // cycles with no transfer on any channel before the run is declared hung
  localparam int  STALL_LIMIT    = 4000;

  localparam longint FRAC_SCALE = 64'sd1 << FRAC_BITS;
  localparam longint S32_HI     = 64'sd2147483647;
  localparam longint S32_LO     = -64'sd2147483648;

  localparam logic [DATA_W-1:0] POS_FULL = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_FULL = 32'h8000_0000;

  // register reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 23'd65536;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 23'd6554;
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 23'd655;
  localparam logic [PER_W-1:0]  RST_PERIOD     = 17'd66;
  localparam logic [GAIN_W-1:0] GAIN_FULL      = 23'h7F_FFFF;
  localparam logic [PER_W-1:0]  PERIOD_FULL    = 17'h1_FFFF;

  // register indexes past the end of the map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [DATA_W-1:0] accel_x;
    logic signed [DATA_W-1:0] accel_y;
    logic signed [DATA_W-1:0] accel_z;
    logic signed [DATA_W-1:0] target_accel_x;
    logic signed [DATA_W-1:0] target_accel_y;
    logic signed [DATA_W-1:0] target_accel_z;
    logic signed [DATA_W-1:0] velocity_x;
    logic signed [DATA_W-1:0] velocity_y;
    logic signed [DATA_W-1:0] velocity_z;
    logic signed [DATA_W-1:0] angle_x;
    logic signed [DATA_W-1:0] angle_y;
    logic signed [DATA_W-1:0] angle_z;
  } sample_t;

  // same bits as sample_t, one element per field, for generic generation
  typedef logic [NUM_FIELDS-1:0][DATA_W-1:0] sample_raw_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } thrust_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctpid_cfg_if    cfg_if ();
  ctpid_sample_if smp_if ();
  ctpid_result_if thr_if ();

  cascaded_three_axis_pid_unit #(
    .AXES      (NUM_AX),
    .STAGES    (NUM_ST),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .sample_i (smp_if),
    .thrust_o (thr_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers and per-controller integral / last error,
  // indexed stage*NUM_AX + axis like the hardware.
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] prop_gain_q;
  logic [GAIN_W-1:0] integ_gain_q;
  logic [GAIN_W-1:0] deriv_gain_q;
  logic [PER_W-1:0]  period_q [NUM_ST];
  longint            integ_sum_q [NUM_CTRL];
  longint            err_prev_q  [NUM_CTRL];

  thrust_t thrust_expected_q [$];

  // Bench control: idling on/off, burst odds per side, mismatch bookkeeping.
  bit idle_en;
  int gap_pct;
  int stall_pct;
  int stall_left;
  int mismatches;
  int quiet_cycles;

  function automatic longint clamp32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // One controller update. A zero period register acts as the least step.
  // >>> on a signed longint floors, / truncates toward zero.
  function automatic longint pid_step(input int idx, input longint tgt, input longint meas,
                                      input logic [PER_W-1:0] per);
    longint dt, err, integ, der, sum;
    dt    = (per == '0) ? 64'sd1 : longint'(per);
    err   = clamp32(tgt - meas);
    integ = clamp32(integ_sum_q[idx] + ((err * dt) >>> FRAC_BITS));
    der   = clamp32(((err - err_prev_q[idx]) * FRAC_SCALE) / dt);
    sum   = longint'(prop_gain_q) * err + longint'(integ_gain_q) * integ
          + longint'(deriv_gain_q) * der;
    integ_sum_q[idx] = integ;
    err_prev_q[idx]  = err;
    return clamp32(sum >>> FRAC_BITS);
  endfunction

  // Full cascade for one sample: stage outputs feed the next stage's targets.
  function automatic thrust_t pid_cascade(input sample_t s);
    longint  meas  [NUM_ST][NUM_AX];
    longint  carry [NUM_AX];
    thrust_t t;
    meas[0][0] = $signed(s.accel_x);
    meas[0][1] = $signed(s.accel_y);
    meas[0][2] = $signed(s.accel_z);
    meas[1][0] = $signed(s.velocity_x);
    meas[1][1] = $signed(s.velocity_y);
    meas[1][2] = $signed(s.velocity_z);
    meas[2][0] = $signed(s.angle_x);
    meas[2][1] = $signed(s.angle_y);
    meas[2][2] = $signed(s.angle_z);
    carry[0]   = $signed(s.target_accel_x);
    carry[1]   = $signed(s.target_accel_y);
    carry[2]   = $signed(s.target_accel_z);
    for (int st = 0; st < NUM_ST; st++) begin
      for (int ax = 0; ax < NUM_AX; ax++) begin
        carry[ax] = pid_step(st * NUM_AX + ax, carry[ax], meas[st][ax], period_q[st]);
      end
    end
    t.x = carry[0][DATA_W-1:0];
    t.y = carry[1][DATA_W-1:0];
    t.z = carry[2][DATA_W-1:0];
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mix of rail values, full-range noise and small Q16.16 magnitudes.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return POS_FULL;
          1:       return NEG_FULL;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      1, 2, 3: return $urandom();
      default: return DATA_W'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  // Next sample of a stream: a small random walk from the previous one
  // (plausible flight data, so integrals build up instead of pinning at the
  // rails), or, with odds of noise_pct percent, a fresh noisy sample.
  function automatic sample_t next_sample(input sample_t prev, input int noise_pct);
    sample_raw_t r;
    bit          noisy;
    r     = sample_raw_t'(prev);
    noisy = ($urandom_range(0, 99) < noise_pct);
    for (int k = 0; k < NUM_FIELDS; k++) begin
      if (noisy) begin
        r[k] = pick_value();
      end else begin
        r[k] = r[k] + DATA_W'($signed($urandom_range(0, 16383)) - 8192);
      end
    end
    return sample_t'(r);
  endfunction

  // One sample transfer, with an optional idle burst in front of it.
  // The expectation is queued at the transfer edge.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = (idle_en && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      @(negedge clk_i);
      smp_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    smp_if.accel_x        <= s.accel_x;
    smp_if.accel_y        <= s.accel_y;
    smp_if.accel_z        <= s.accel_z;
    smp_if.target_accel_x <= s.target_accel_x;
    smp_if.target_accel_y <= s.target_accel_y;
    smp_if.target_accel_z <= s.target_accel_z;
    smp_if.velocity_x     <= s.velocity_x;
    smp_if.velocity_y     <= s.velocity_y;
    smp_if.velocity_z     <= s.velocity_z;
    smp_if.angle_x        <= s.angle_x;
    smp_if.angle_y        <= s.angle_y;
    smp_if.angle_z        <= s.angle_z;
    smp_if.valid          <= 1'b1;
    do @(posedge clk_i); while (!smp_if.ready);
    thrust_expected_q.push_back(pid_cascade(s));
  endtask

  // Stop sending and wait until every queued thrust has come back.
  task automatic wait_results_drained();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (thrust_expected_q.size() != 0) @(posedge clk_i);
  endtask

  // One register write; the shadow copy follows at the transfer edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= val;
    cfg_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_PROP_GAIN:    prop_gain_q  = val[GAIN_W-1:0];
      REG_INTEG_GAIN:   integ_gain_q = val[GAIN_W-1:0];
      REG_DERIV_GAIN:   deriv_gain_q = val[GAIN_W-1:0];
      REG_ACCEL_PERIOD: period_q[0]  = val[PER_W-1:0];
      REG_VEL_PERIOD:   period_q[1]  = val[PER_W-1:0];
      REG_ANGLE_PERIOD: period_q[2]  = val[PER_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [PER_W-1:0] p_acc,
                              input logic [PER_W-1:0] p_vel, input logic [PER_W-1:0] p_ang);
    write_reg(REG_PROP_GAIN, CFG_DATA_W'(kp));
    write_reg(REG_INTEG_GAIN, CFG_DATA_W'(ki));
    write_reg(REG_DERIV_GAIN, CFG_DATA_W'(kd));
    write_reg(REG_ACCEL_PERIOD, CFG_DATA_W'(p_acc));
    write_reg(REG_VEL_PERIOD, CFG_DATA_W'(p_vel));
    write_reg(REG_ANGLE_PERIOD, CFG_DATA_W'(p_ang));
  endtask

  task automatic check_axis(input string name, input logic signed [DATA_W-1:0] want,
                            input logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset gains and periods: a quiet sample, then a few steps so the
  // integrals and last errors carried between samples matter.
  task automatic test_reset_defaults();
    sample_t s;
    s = '0;
    send_sample(s);
    s.target_accel_x = 32'sh0001_0000;
    s.target_accel_y = -32'sh0000_8000;
    s.target_accel_z = 32'sh0002_0000;
    s.velocity_x     = 32'sh0000_4000;
    s.angle_y        = -32'sh0001_8000;
    s.accel_z        = 32'sh0000_0100;
    repeat (3) send_sample(s);
  endtask

  // Rails on every field, saturating errors both ways, alternating bit patterns.
  task automatic test_field_extremes();
    sample_t s;
    s = {NUM_FIELDS{POS_FULL}};
    send_sample(s);
    s = {NUM_FIELDS{NEG_FULL}};
    send_sample(s);
    s = {NUM_FIELDS{NEG_FULL}};
    s.target_accel_x = POS_FULL;
    s.target_accel_y = POS_FULL;
    s.target_accel_z = POS_FULL;
    send_sample(s);
    s = {NUM_FIELDS{POS_FULL}};
    s.target_accel_x = NEG_FULL;
    s.target_accel_y = NEG_FULL;
    s.target_accel_z = NEG_FULL;
    send_sample(s);
    s = {NUM_FIELDS{32'hAAAA_AAAA}};
    send_sample(s);
    s = {NUM_FIELDS{32'h5555_5555}};
    send_sample(s);
  endtask

  // Zero periods (least step), widest gains and periods, zero gains, and
  // writes to indexes past the register map that must change nothing.
  task automatic test_register_extremes();
    sample_t s;
    wait_results_drained();
    load_setting(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN, '0, '0, '0);
    s = {NUM_FIELDS{NEG_FULL}};
    s.target_accel_x = POS_FULL;
    send_sample(s);
    s = {NUM_FIELDS{32'h0003_0000}};
    s.velocity_y = -32'sh0004_0000;
    send_sample(s);
    wait_results_drained();
    load_setting(GAIN_FULL, GAIN_FULL, GAIN_FULL, PERIOD_FULL, PERIOD_FULL, PERIOD_FULL);
    s = {NUM_FIELDS{POS_FULL}};
    s.accel_y = NEG_FULL;
    send_sample(s);
    s = {NUM_FIELDS{32'h0000_0001}};
    send_sample(s);
    wait_results_drained();
    load_setting('0, '0, '0, PERIOD_FULL, 17'd1, 17'd65536);
    send_sample(next_sample(s, 100));
    wait_results_drained();
    load_setting(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                 RST_PERIOD, RST_PERIOD, RST_PERIOD);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 23'h15_A5A5);
    s = {NUM_FIELDS{32'h0001_0000}};
    s.target_accel_z = -32'sh0002_0000;
    send_sample(s);
    send_sample(s);
  endtask

  // Several register settings, rails among them, each with its own stream.
  // Idling switches on and off between settings.
  task automatic test_config_sweep();
    sample_t s;
    s       = '0;
    idle_en = 1'b1;
    for (int setting = 0; setting < 7; setting++) begin
      wait_results_drained();
      case (setting)
        0: load_setting(RST_PROP_GAIN, RST_INTEG_GAIN, RST_DERIV_GAIN,
                        RST_PERIOD, RST_PERIOD, RST_PERIOD);
        1: load_setting(GAIN_FULL, GAIN_FULL, GAIN_FULL, PERIOD_FULL, PERIOD_FULL, PERIOD_FULL);
        2: load_setting(GAIN_FULL, GAIN_FULL, GAIN_FULL, 17'd1, 17'd1, 17'd1);
        3: load_setting('0, '0, '0, 17'd65536, '0, 17'd1);
        default: load_setting(GAIN_W'($urandom_range(0, 8388607)),
                              GAIN_W'($urandom_range(0, 8388607)),
                              GAIN_W'($urandom_range(0, 8388607)),
                              PER_W'($urandom_range(0, 131071)),
                              PER_W'($urandom_range(0, 4096)),
                              PER_W'($urandom_range(0, 131071)));
      endcase
      gap_pct   = (setting % 3 == 0) ? 0 : 35;
      stall_pct = (setting % 2 == 0) ? 40 : 0;
      repeat (110) begin
        s = next_sample(s, 40);
        send_sample(s);
      end
    end
  endtask

  // Long tracking stream at a realistic setting with occasional noise.
  task automatic test_tracking_stream();
    sample_t s;
    wait_results_drained();
    load_setting(23'd98304, 23'd13107, 23'd1311, 17'd66, 17'd655, 17'd6554);
    s = '0;
    for (int chunk = 0; chunk < 6; chunk++) begin
      gap_pct   = $urandom_range(0, 60);
      stall_pct = (chunk == 2) ? 0 : $urandom_range(10, 70);
      repeat (100) begin
        s = next_sample(s, 15);
        send_sample(s);
      end
    end
  endtask

  // Sender holds off until every expected thrust is back, in short bursts.
  task automatic test_drain_pauses();
    sample_t s;
    s         = '0;
    gap_pct   = 20;
    stall_pct = 50;
    repeat (12) begin
      repeat ($urandom_range(1, 8)) begin
        s = next_sample(s, 30);
        send_sample(s);
      end
      wait_results_drained();
    end
  endtask

  // Back-to-back samples with both sides always ready.
  task automatic test_full_rate();
    sample_t s;
    s       = '0;
    idle_en = 1'b0;
    repeat (250) begin
      s = next_sample(s, 25);
      send_sample(s);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random ready bursts, and the checker.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      thr_if.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 13) - 1;
      thr_if.ready <= 1'b0;
    end else begin
      thr_if.ready <= 1'b1;
    end
  end

  // Every thrust transfer must match the oldest expectation, field by field.
  always @(posedge clk_i) begin
    thrust_t want;
    if (rst_ni && thr_if.valid && thr_if.ready) begin
      if (thrust_expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: thrust transfer with none expected, actual %0d %0d %0d",
                 $time, thr_if.thrust_x, thr_if.thrust_y, thr_if.thrust_z);
      end else begin
        want = thrust_expected_q.pop_front();
        check_axis("thrust_x", want.x, thr_if.thrust_x);
        check_axis("thrust_y", want.y, thr_if.thrust_y);
        check_axis("thrust_z", want.z, thr_if.thrust_z);
      end
    end
  end

  // Hang detector: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (thr_if.valid && thr_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("cascaded_three_axis_pid_unit_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni                = 1'b0;
    smp_if.valid          = 1'b0;
    smp_if.accel_x        = '0;
    smp_if.accel_y        = '0;
    smp_if.accel_z        = '0;
    smp_if.target_accel_x = '0;
    smp_if.target_accel_y = '0;
    smp_if.target_accel_z = '0;
    smp_if.velocity_x     = '0;
    smp_if.velocity_y     = '0;
    smp_if.velocity_z     = '0;
    smp_if.angle_x        = '0;
    smp_if.angle_y        = '0;
    smp_if.angle_z        = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.reg_idx        = '0;
    cfg_if.wdata          = '0;
    thr_if.ready          = 1'b0;
    idle_en               = 1'b0;
    gap_pct               = 0;
    stall_pct             = 0;
    stall_left            = 0;
    mismatches            = 0;
    quiet_cycles          = 0;

    // predictor mirrors the reset state
    prop_gain_q  = RST_PROP_GAIN;
    integ_gain_q = RST_INTEG_GAIN;
    deriv_gain_q = RST_DERIV_GAIN;
    for (int k = 0; k < NUM_ST; k++) period_q[k] = RST_PERIOD;
    for (int k = 0; k < NUM_CTRL; k++) begin
      integ_sum_q[k] = 0;
      err_prev_q[k]  = 0;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_config_sweep();
    test_tracking_stream();
    test_drain_pauses();
    test_full_rate();

    // let any stray transfer show up before judging
    wait_results_drained();
    repeat (2 * SAMPLE_LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("cascaded_three_axis_pid_unit_tb passed");
    end else begin
      $display("cascaded_three_axis_pid_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> cascaded_three_axis_pid_unit.f
+incdir+src
src/ctpid_pkg.sv
src/ctpid_if.sv
src/ctpid_cfg.sv
src/ctpid_mul.sv
src/ctpid_div.sv
src/cascaded_three_axis_pid_unit.sv
verif/cascaded_three_axis_pid_unit_tb.sv
